### rtl/rrs_pkg.sv
`default_nettype none
package rrs_pkg;

    localparam int MAX_PROC = 64;
    localparam int IDX_W    = $clog2(MAX_PROC);
    localparam int CNT_W    = IDX_W + 1;
    localparam int TIME_W   = 23;
    localparam int SUM_W    = 29;

    // Sequencer states, one-hot.
    typedef enum logic [14:0] {
        ST_LOAD      = 15'b000000000000001,
        ST_SORT_KEY  = 15'b000000000000010,
        ST_SORT_CAP  = 15'b000000000000100,
        ST_SORT_SCAN = 15'b000000000001000,
        ST_SORT_WR   = 15'b000000000010000,
        ST_SIM_ORD   = 15'b000000000100000,
        ST_SIM_IDX   = 15'b000000001000000,
        ST_SIM_EXE   = 15'b000000010000000,
        ST_SIM_END   = 15'b000000100000000,
        ST_JUMP_PRE  = 15'b000001000000000,
        ST_JUMP_SCAN = 15'b000010000000000,
        ST_JUMP_END  = 15'b000100000000000,
        ST_OUT_RD    = 15'b001000000000000,
        ST_OUT_CALC  = 15'b010000000000000,
        ST_OUT_WAIT  = 15'b100000000000000
    } state_t;

    // One result item.
    typedef struct packed {
        logic [CNT_W-1:0]  process_id;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] turnaround_time;
        logic [TIME_W-1:0] waiting_time;
        logic [TIME_W-1:0] response_time;
        logic [SUM_W-1:0]  sum_waiting;
        logic [SUM_W-1:0]  sum_turnaround;
        logic              last_result;
    } result_t;

endpackage
`default_nettype wire

### rtl/round_robin_schedule_simulator_core.sv
`default_nettype none
// Round-robin schedule simulator.
// The s_ channel loads one process per item: s_tdata holds arrival and burst
// time, s_tlast marks the final process of a set. Loading takes one item per
// cycle. The item with s_tlast set starts a run: a stable rank sort by arrival,
// then the round-robin scans, plus a jump to the nearest later arrival each
// time a scan finds no ready process, all through a single-port read of the
// process tables. While the run lasts s_tready is low. Results then leave on
// the m_ channel in process-id order; each item is read, computed and offered
// before the next is read, which waits until it is taken; m_tlast marks the
// highest process id. A stalled result holds m_tvalid and m_tdata until taken.
// After the last result the block returns to loading a new set.
// cfg_we writes the time quantum from cfg_wdata; a quantum of zero acts as one.
// Reset sets the quantum to four and empties the set; table contents
// are not cleared, since only loaded entries are read.
module round_robin_schedule_simulator_core
    import rrs_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [15:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // arrival_time[15:0], burst_time[31:16]
    input  wire logic         s_tlast,   // last_process
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // process_id[6:0], completion_time[29:7], turnaround_time[52:30],
    // waiting_time[75:53], response_time[98:76], sum_waiting[127:99],
    // sum_turnaround[156:128], zero fill[159:157]
    output logic [159:0]      m_tdata,
    output logic              m_tlast    // last_result
);

    state_t            state_reg, state_next;
    logic [15:0]       q_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, n_reg, n_next;
    logic [CNT_W-1:0]  i_reg, i_next, t_reg, t_next, rank_reg, rank_next;
    logic [CNT_W-1:0]  fin_cnt_reg, fin_cnt_next;
    logic [15:0]       key_reg, key_next, nxt_reg, nxt_next;
    logic [TIME_W-1:0] clk_reg, clk_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic              ran_reg, ran_next, found_reg, found_next;
    logic [MAX_PROC-1:0] started_reg, started_next;

    logic [15:0]       arr_mem [MAX_PROC];
    logic [15:0]       burst_mem [MAX_PROC];
    logic [15:0]       rem_mem [MAX_PROC];
    logic [IDX_W-1:0]  ord_mem [MAX_PROC];
    logic [TIME_W-1:0] fin_mem [MAX_PROC];
    logic [TIME_W-1:0] first_mem [MAX_PROC];
    logic [15:0]       arr_q, burst_q, rem_q;
    logic [IDX_W-1:0]  ord_q;
    logic [TIME_W-1:0] fin_q, first_q;

    logic [IDX_W-1:0]  rd_idx, wr_idx;
    logic              load_we, rem_we, ord_we, fin_we, first_we;
    logic [15:0]       rem_wdata, q_eff;
    logic [TIME_W-1:0] fin_wdata;
    logic              accept, store, runs, cand, earlier;
    logic              stats_clear, stats_load;
    result_t           res;

    assign q_eff    = (q_reg == 16'd0) ? 16'd1 : q_reg;
    assign accept   = s_tvalid && s_tready;
    assign store    = (cnt_reg != CNT_W'(MAX_PROC));
    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_OUT_WAIT);
    assign wr_idx   = (state_reg == ST_LOAD) ? cnt_reg[IDX_W-1:0] : slot_reg;

    // Shared compare results for sorting, running and jumping.
    assign earlier = (arr_q < key_reg) || ((arr_q == key_reg) && (t_reg < i_reg));
    assign runs    = (rem_q != 16'd0) && ({7'd0, arr_q} <= clk_reg);
    assign cand    = (rem_q != 16'd0) && ({7'd0, arr_q} > clk_reg) &&
                     (!found_reg || (arr_q < nxt_reg));

    // Table read address for each step.
    always_comb begin
        unique case (state_reg)
            ST_SORT_KEY, ST_OUT_RD:   rd_idx = i_reg[IDX_W-1:0];
            ST_SORT_SCAN, ST_JUMP_SCAN: rd_idx = IDX_W'(t_reg + CNT_W'(1));
            ST_SIM_IDX:               rd_idx = ord_q;
            default:                  rd_idx = '0;
        endcase
    end

    // Process tables with registered reads.
    always_ff @(posedge aclk) begin
        if (load_we) begin
            arr_mem[wr_idx]   <= s_tdata[15:0];
            burst_mem[wr_idx] <= (s_tdata[31:16] == 16'd0) ? 16'd1 : s_tdata[31:16];
        end
        if (rem_we) rem_mem[wr_idx] <= rem_wdata;
        if (fin_we) fin_mem[wr_idx] <= fin_wdata;
        if (first_we) first_mem[wr_idx] <= clk_reg;
        if (ord_we) ord_mem[rank_reg[IDX_W-1:0]] <= i_reg[IDX_W-1:0];
        arr_q   <= arr_mem[rd_idx];
        burst_q <= burst_mem[rd_idx];
        rem_q   <= rem_mem[rd_idx];
        fin_q   <= fin_mem[rd_idx];
        first_q <= first_mem[rd_idx];
        ord_q   <= ord_mem[i_reg[IDX_W-1:0]];
    end

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        t_next       = t_reg;
        rank_next    = rank_reg;
        fin_cnt_next = fin_cnt_reg;
        key_next     = key_reg;
        nxt_next     = nxt_reg;
        clk_next     = clk_reg;
        slot_next    = slot_reg;
        ran_next     = ran_reg;
        found_next   = found_reg;
        started_next = started_reg;
        load_we      = 1'b0;
        rem_we       = 1'b0;
        rem_wdata    = s_tdata[31:16];
        ord_we       = 1'b0;
        fin_we       = 1'b0;
        fin_wdata    = clk_reg + {7'd0, rem_q};
        first_we     = 1'b0;
        stats_clear  = 1'b0;
        stats_load   = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    if (store) begin
                        load_we   = 1'b1;
                        rem_we    = 1'b1;
                        rem_wdata = (s_tdata[31:16] == 16'd0) ? 16'd1 : s_tdata[31:16];
                        started_next[cnt_reg[IDX_W-1:0]] = 1'b0;
                    end
                    cnt_next = cnt_reg + CNT_W'(store);
                    if (s_tlast) begin
                        n_next     = cnt_reg + CNT_W'(store);
                        i_next     = '0;
                        state_next = ST_SORT_KEY;
                    end
                end
            end
            ST_SORT_KEY: state_next = ST_SORT_CAP;
            ST_SORT_CAP: begin
                key_next   = arr_q;
                t_next     = '0;
                rank_next  = '0;
                state_next = ST_SORT_SCAN;
            end
            // Rank of entry i counts entries that sort before it.
            ST_SORT_SCAN: begin
                rank_next = rank_reg + CNT_W'(earlier);
                t_next    = t_reg + CNT_W'(1);
                if (t_reg == n_reg - CNT_W'(1)) state_next = ST_SORT_WR;
            end
            ST_SORT_WR: begin
                ord_we = 1'b1;
                if (rank_reg == '0) clk_next = {7'd0, key_reg};
                i_next = i_reg + CNT_W'(1);
                if (i_reg + CNT_W'(1) == n_reg) begin
                    i_next       = '0;
                    ran_next     = 1'b0;
                    fin_cnt_next = '0;
                    state_next   = ST_SIM_ORD;
                end else begin
                    state_next = ST_SORT_KEY;
                end
            end
            ST_SIM_ORD: state_next = ST_SIM_IDX;
            ST_SIM_IDX: begin
                slot_next  = ord_q;
                state_next = ST_SIM_EXE;
            end
            // One turn of the process in slot_reg.
            ST_SIM_EXE: begin
                if (runs) begin
                    ran_next = 1'b1;
                    if (!started_reg[slot_reg]) begin
                        started_next[slot_reg] = 1'b1;
                        first_we = 1'b1;
                    end
                    rem_we = 1'b1;
                    if (rem_q <= q_eff) begin
                        rem_wdata    = 16'd0;
                        fin_we       = 1'b1;
                        clk_next     = fin_wdata;
                        fin_cnt_next = fin_cnt_reg + CNT_W'(1);
                    end else begin
                        rem_wdata = rem_q - q_eff;
                        clk_next  = clk_reg + {7'd0, q_eff};
                    end
                end
                i_next = i_reg + CNT_W'(1);
                state_next = (i_reg + CNT_W'(1) == n_reg) ? ST_SIM_END : ST_SIM_ORD;
            end
            ST_SIM_END: begin
                i_next = '0;
                if (fin_cnt_reg == n_reg) begin
                    stats_clear = 1'b1;
                    state_next  = ST_OUT_RD;
                end else if (ran_reg) begin
                    ran_next   = 1'b0;
                    state_next = ST_SIM_ORD;
                end else begin
                    found_next = 1'b0;
                    state_next = ST_JUMP_PRE;
                end
            end
            ST_JUMP_PRE: begin
                t_next     = '0;
                state_next = ST_JUMP_SCAN;
            end
            // Search for the nearest later arrival of an unfinished process.
            ST_JUMP_SCAN: begin
                if (cand) begin
                    found_next = 1'b1;
                    nxt_next   = arr_q;
                end
                t_next = t_reg + CNT_W'(1);
                if (t_reg == n_reg - CNT_W'(1)) state_next = ST_JUMP_END;
            end
            ST_JUMP_END: begin
                i_next = '0;
                if (found_reg) begin
                    clk_next   = {7'd0, nxt_reg};
                    ran_next   = 1'b0;
                    state_next = ST_SIM_ORD;
                end else begin
                    stats_clear = 1'b1;
                    state_next  = ST_OUT_RD;
                end
            end
            ST_OUT_RD: state_next = ST_OUT_CALC;
            ST_OUT_CALC: begin
                stats_load = 1'b1;
                state_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (m_tready) begin
                    i_next = i_reg + CNT_W'(1);
                    if (i_reg + CNT_W'(1) == n_reg) begin
                        cnt_next   = '0;
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            n_reg       <= '0;
            i_reg       <= '0;
            fin_cnt_reg <= '0;
            clk_reg     <= '0;
            ran_reg     <= 1'b0;
            found_reg   <= 1'b0;
            started_reg <= '0;
            q_reg       <= 16'd4;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            n_reg       <= n_next;
            i_reg       <= i_next;
            fin_cnt_reg <= fin_cnt_next;
            clk_reg     <= clk_next;
            ran_reg     <= ran_next;
            found_reg   <= found_next;
            started_reg <= started_next;
            if (cfg_we) q_reg <= cfg_wdata;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        t_reg    <= t_next;
        rank_reg <= rank_next;
        key_reg  <= key_next;
        nxt_reg  <= nxt_next;
        slot_reg <= slot_next;
    end

    rrs_stats u_stats (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (stats_clear),
        .load    (stats_load),
        .pid     (i_reg + CNT_W'(1)),
        .last    (i_reg + CNT_W'(1) == n_reg),
        .fin     (fin_q),
        .first   (first_q),
        .arr     (arr_q),
        .burst   (burst_q),
        .res     (res)
    );

    assign m_tdata = {3'd0, res.sum_turnaround, res.sum_waiting, res.response_time,
                      res.waiting_time, res.turnaround_time, res.completion_time,
                      res.process_id};
    assign m_tlast = res.last_result;

endmodule
`default_nettype wire

### rtl/rrs_stats.sv
`default_nettype none
module rrs_stats
    import rrs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              clear,
    input  wire logic              load,
    input  wire logic [CNT_W-1:0]  pid,
    input  wire logic              last,
    input  wire logic [TIME_W-1:0] fin,
    input  wire logic [TIME_W-1:0] first,
    input  wire logic [15:0]       arr,
    input  wire logic [15:0]       burst,
    output result_t                res
);

    logic [SUM_W-1:0]  sum_w_reg, sum_t_reg;
    logic [TIME_W-1:0] tat, wt, rt;
    result_t           res_reg;

    // Per-process figures, wrapping at the field width.
    assign tat = fin - {7'd0, arr};
    assign wt  = tat - {7'd0, burst};
    assign rt  = first - {7'd0, arr};

    // Result register and running totals.
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            sum_w_reg <= '0;
            sum_t_reg <= '0;
        end else if (load) begin
            sum_w_reg <= sum_w_reg + {6'd0, wt};
            sum_t_reg <= sum_t_reg + {6'd0, tat};
        end
        if (load) begin
            res_reg.process_id      <= pid;
            res_reg.completion_time <= fin;
            res_reg.turnaround_time <= tat;
            res_reg.waiting_time    <= wt;
            res_reg.response_time   <= rt;
            res_reg.sum_waiting     <= sum_w_reg + {6'd0, wt};
            res_reg.sum_turnaround  <= sum_t_reg + {6'd0, tat};
            res_reg.last_result     <= last;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

### rtl/rrs_checker.sv
`default_nettype none
module rrs_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [159:0] m_tdata
);

    // A stalled result stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    // Loading and result delivery never overlap.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is offered");

    // No result item right after reset.
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // Process ids are one-based.
    a_pid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[6:0] != 7'd0)
        else $error("zero process id");

endmodule

bind round_robin_schedule_simulator_core rrs_checker u_rrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps

import rrs_pkg::*;

// Scoreboard: keeps its own copy of the process set and the quantum, runs the
// round-robin schedule when a set closes and queues the per-process reports.
class rr_scoreboard;
    int unsigned quantum;
    int unsigned arrival_q[MAX_PROC];
    int unsigned burst_q[MAX_PROC];
    int unsigned n_loaded;
    result_t     report_q[$];
    int unsigned errors;
    int unsigned reports_seen;
    int unsigned sets_run;

    function new();
        quantum = 4;
        n_loaded = 0;
        errors = 0;
        reports_seen = 0;
        sets_run = 0;
    endfunction

    // Record one accepted process; on the closing item, schedule the set.
    function void note_process(logic [15:0] arr, logic [15:0] bur, logic closing);
        int unsigned order[MAX_PROC];
        int unsigned remain[MAX_PROC];
        int unsigned finish_at[MAX_PROC];
        int unsigned first_at[MAX_PROC];
        bit          started[MAX_PROC];
        int unsigned q, clk_now, done, key, j, s, nxt, tat, wt, rt, sw, st;
        bit          ran, found;
        result_t     r;
        if (n_loaded < MAX_PROC) begin
            arrival_q[n_loaded] = 32'(arr);
            burst_q[n_loaded] = (bur == 0) ? 32'd1 : 32'(bur);
            n_loaded++;
        end
        if (!closing)
            return;
        q = (quantum == 0) ? 1 : quantum;
        // Stable insertion sort by arrival.
        for (int i = 0; i < n_loaded; i++) begin
            order[i] = i;
            remain[i] = burst_q[i];
            started[i] = 0;
        end
        for (int i = 1; i < n_loaded; i++) begin
            key = order[i];
            j = i;
            while (j > 0 && arrival_q[order[j-1]] > arrival_q[key]) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = key;
        end
        clk_now = arrival_q[order[0]];
        done = 0;
        while (done < n_loaded) begin
            ran = 0;
            for (int i = 0; i < n_loaded; i++) begin
                s = order[i];
                if (remain[s] == 0 || arrival_q[s] > clk_now)
                    continue;
                ran = 1;
                if (!started[s]) begin
                    started[s] = 1;
                    first_at[s] = clk_now;
                end
                if (remain[s] <= q) begin
                    clk_now += remain[s];
                    remain[s] = 0;
                    finish_at[s] = clk_now;
                    done++;
                end else begin
                    clk_now += q;
                    remain[s] -= q;
                end
            end
            // Nothing ready: jump to the nearest later arrival.
            if (!ran) begin
                found = 0;
                nxt = 0;
                for (int k = 0; k < n_loaded; k++) begin
                    if (remain[k] > 0 && arrival_q[k] > clk_now &&
                        (!found || arrival_q[k] < nxt)) begin
                        nxt = arrival_q[k];
                        found = 1;
                    end
                end
                if (!found)
                    break;
                clk_now = nxt;
            end
        end
        sw = 0;
        st = 0;
        for (int k = 0; k < n_loaded; k++) begin
            tat = finish_at[k] - arrival_q[k];
            wt = tat - burst_q[k];
            rt = first_at[k] - arrival_q[k];
            sw = (sw + wt) & 32'h1FFF_FFFF;
            st = (st + tat) & 32'h1FFF_FFFF;
            r.process_id = CNT_W'(k + 1);
            r.completion_time = TIME_W'(finish_at[k]);
            r.turnaround_time = TIME_W'(tat);
            r.waiting_time = TIME_W'(wt);
            r.response_time = TIME_W'(rt);
            r.sum_waiting = SUM_W'(sw);
            r.sum_turnaround = SUM_W'(st);
            r.last_result = (k + 1 == n_loaded);
            report_q.push_back(r);
        end
        n_loaded = 0;
        sets_run++;
    endfunction

    // Compare one report from the block against the oldest expectation.
    function void check_result(result_t got);
        result_t exp_r;
        if (report_q.size() == 0) begin
            $error("unexpected report for process %0d", got.process_id);
            errors++;
            return;
        end
        exp_r = report_q.pop_front();
        reports_seen++;
        if (got.process_id !== exp_r.process_id) begin
            $error("process_id: expected %0d, got %0d", exp_r.process_id, got.process_id);
            errors++;
        end
        if (got.completion_time !== exp_r.completion_time) begin
            $error("completion_time: expected %0d, got %0d",
                   exp_r.completion_time, got.completion_time);
            errors++;
        end
        if (got.turnaround_time !== exp_r.turnaround_time) begin
            $error("turnaround_time: expected %0d, got %0d",
                   exp_r.turnaround_time, got.turnaround_time);
            errors++;
        end
        if (got.waiting_time !== exp_r.waiting_time) begin
            $error("waiting_time: expected %0d, got %0d",
                   exp_r.waiting_time, got.waiting_time);
            errors++;
        end
        if (got.response_time !== exp_r.response_time) begin
            $error("response_time: expected %0d, got %0d",
                   exp_r.response_time, got.response_time);
            errors++;
        end
        if (got.sum_waiting !== exp_r.sum_waiting) begin
            $error("sum_waiting: expected %0d, got %0d", exp_r.sum_waiting, got.sum_waiting);
            errors++;
        end
        if (got.sum_turnaround !== exp_r.sum_turnaround) begin
            $error("sum_turnaround: expected %0d, got %0d",
                   exp_r.sum_turnaround, got.sum_turnaround);
            errors++;
        end
        if (got.last_result !== exp_r.last_result) begin
            $error("last_result: expected %0d, got %0d", exp_r.last_result, got.last_result);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int CYCLE_LIMIT = 6000000;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [15:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;
    logic         m_tlast;

    rr_scoreboard sched;
    int unsigned  cycles;
    int unsigned  items_sent;
    bit           stall_mode;

    round_robin_schedule_simulator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Clock.
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Monitors: note accepted processes and check accepted reports.
    always @(posedge aclk) begin
        result_t got;
        if (aresetn && s_tvalid && s_tready)
            sched.note_process(s_tdata[15:0], s_tdata[31:16], s_tlast);
        if (aresetn && m_tvalid && m_tready) begin
            got.process_id = m_tdata[6:0];
            got.completion_time = m_tdata[29:7];
            got.turnaround_time = m_tdata[52:30];
            got.waiting_time = m_tdata[75:53];
            got.response_time = m_tdata[98:76];
            got.sum_waiting = m_tdata[127:99];
            got.sum_turnaround = m_tdata[156:128];
            got.last_result = m_tlast;
            sched.check_result(got);
        end
    end

    // Receiver: switches between always-ready stretches and random stalls.
    always @(negedge aclk) begin
        if ($urandom_range(0, 63) == 0)
            stall_mode = !stall_mode;
        if (stall_mode)
            m_tready = ($urandom_range(0, 3) != 0) ? 1'b0 : 1'b1;
        else
            m_tready = 1'b1;
    end

    // Present one process and hold it until accepted.
    task automatic send_process(input logic [15:0] arr, input logic [15:0] bur,
                                input logic closing);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = {bur, arr};
        s_tlast = closing;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Drop valid for a while between bursts.
    task automatic sender_gap(input int unsigned len);
        if (len == 0)
            return;
        @(negedge aclk);
        s_tvalid = 1'b0;
        repeat (len - 1) @(negedge aclk);
    endtask

    // Wait for every report, let the block settle, then write the quantum.
    task automatic set_quantum(input logic [15:0] q);
        sender_gap(1);
        while (sched.report_q.size() != 0)
            @(negedge aclk);
        repeat (10) @(negedge aclk);
        cfg_we = 1'b1;
        cfg_wdata = q;
        sched.quantum = 32'(q);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // One set of processes with random content; bursts scale with the quantum
    // so that long sets stay short in simulated cycles.
    task automatic random_set(input int unsigned n, input bit wide_arrivals);
        int unsigned bmax, burst_left, a, b;
        bmax = (sched.quantum == 0) ? 8 : sched.quantum * 6;
        if (bmax > 65535)
            bmax = 65535;
        if (n > 16 && bmax > 64)
            bmax = 64 + sched.quantum;
        if (bmax > 65535)
            bmax = 65535;
        burst_left = 0;
        for (int i = 0; i < n; i++) begin
            a = wide_arrivals ? $urandom_range(0, 65535) : $urandom_range(0, 60);
            b = $urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, bmax);
            if (burst_left == 0) begin
                sender_gap($urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 6));
                burst_left = $urandom_range(1, 8);
            end
            burst_left--;
            send_process(a[15:0], b[15:0], i == n - 1);
        end
    endtask

    initial begin
        logic [15:0] qv;
        int unsigned n;
        sched = new();
        cycles = 0;
        items_sent = 0;
        stall_mode = 0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b1;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: default quantum, single process at the field extremes.
        send_process(16'hFFFF, 16'hFFFF, 1'b1);
        send_process(16'h0000, 16'h0001, 1'b1);
        // Zero burst, equal arrivals for sort stability, and an idle gap
        // that forces a jump to a later arrival.
        send_process(16'd5, 16'd0, 1'b0);
        send_process(16'd5, 16'd9, 1'b0);
        send_process(16'd2, 16'd3, 1'b0);
        send_process(16'd100, 16'd4, 1'b1);
        // Zero quantum acts as one.
        set_quantum(16'd0);
        send_process(16'd3, 16'd3, 1'b0);
        send_process(16'd0, 16'd5, 1'b1);
        // Largest quantum: each process finishes in its first turn.
        set_quantum(16'hFFFF);
        send_process(16'h1234, 16'hFFFF, 1'b0);
        send_process(16'h0000, 16'h8000, 1'b0);
        send_process(16'h5555, 16'h2AAA, 1'b1);
        // Overfull table: two items past the limit, the last one closes the set.
        set_quantum(16'd1);
        for (int i = 0; i < MAX_PROC + 2; i++)
            send_process(i[15:0] % 16'd7, 16'd1 + i[15:0] % 16'd3, i == MAX_PROC + 1);

        // Random sets over a range of quanta.
        while (items_sent < 310) begin
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 3))
                    0: qv = 16'd1;
                    1: qv = 16'($urandom_range(2, 16));
                    2: qv = 16'($urandom_range(0, 65535));
                    default: qv = 16'hFFFF;
                endcase
                set_quantum(qv);
            end
            case ($urandom_range(0, 9))
                0: n = $urandom_range(9, 24);
                1: n = ($urandom_range(0, 3) == 0) ? MAX_PROC : $urandom_range(1, 3);
                default: n = $urandom_range(1, 8);
            endcase
            random_set(n, $urandom_range(0, 3) == 0);
        end
        sender_gap(1);

        while (sched.report_q.size() != 0)
            @(negedge aclk);
        repeat (200) @(negedge aclk);
        $display("Loaded %0d processes in %0d sets; %0d reports checked, %0d mismatches.",
                 items_sent, sched.sets_run, sched.reports_seen, sched.errors);
        if (sched.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
